// File: rtl/sphere_triangle_subdivider_assert.svh
// assertion macros for the sphere triangle subdivider
`ifndef SPHERE_TRIANGLE_SUBDIVIDER_ASSERT_SVH
`define SPHERE_TRIANGLE_SUBDIVIDER_ASSERT_SVH
`ifndef SYNTHESIS
`define STS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next cycle check failed");
`else
`define STS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/sts_pkg.sv
// shared types, constants and helpers of the sphere triangle subdivider
package sts_pkg;

   localparam int MAX_DEPTH       = 3;
   localparam int COORD_FRAC_DEF  = 14;
   localparam int COORD_W         = 16;
   localparam int COLOR_W         = 7;
   localparam int COLOR_MOD       = 100;
   localparam int DEPTH_W         = 2;
   localparam int LVL_W           = 2;
   localparam int NUM_SLOTS       = 3 + 3 * MAX_DEPTH;
   localparam int SLOT_W          = $clog2(NUM_SLOTS);
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(3);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [2:0] vec_type;
   typedef vec_type [2:0] tri_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef slot_type [2:0] slot3_type;

   typedef struct packed {
      logic            in_ld;
      logic            wr_en;
      logic            wr_from_in;
      logic [1:0]      in_sel;
      slot_type        wr_addr;
      logic            rd_en;
      slot_type        rd_addr;
      logic            tmp_ld;
      logic            vec_ld;
      logic            vec_mid;
      logic            norm_start;
      logic            out_ld;
      logic [1:0]      out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic norm_done;
   } dp_status_type;

   // first midpoint slot of a level: ab, bc, ca follow
   function automatic slot_type mid_base(logic [LVL_W-1:0] lvl);
      return SLOT_W'(3 + 3 * int'(lvl));
   endfunction

   // corners of child k of a node: (a,ab,ca) (b,ab,bc) (ca,c,bc) (ab,ca,bc)
   function automatic slot3_type child_corners(slot3_type p, logic [LVL_W-1:0] lvl,
                                               logic [1:0] k);
      slot_type  m0;
      slot_type  m1;
      slot_type  m2;
      slot3_type c;
      m0 = mid_base(lvl);
      m1 = m0 + SLOT_W'(1);
      m2 = m0 + SLOT_W'(2);
      case (k)
         2'd0: begin
            c[0] = p[0]; c[1] = m0; c[2] = m2;
         end
         2'd1: begin
            c[0] = p[1]; c[1] = m0; c[2] = m1;
         end
         2'd2: begin
            c[0] = m2; c[1] = p[2]; c[2] = m1;
         end
         default: begin
            c[0] = m0; c[1] = m2; c[2] = m1;
         end
      endcase
      return c;
   endfunction

endpackage

// File: rtl/sts_norm.sv
// vector normalizer: sum of squares, rounded square root, three divides
module sts_norm import sts_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  vec_type vec_in,
   output logic    done,
   output vec_type res
);

   localparam int NW = 17 + COORD_FRAC_BITS;
   localparam int CW = $clog2(NW);
   localparam logic [NW-1:0] ONE = NW'(1) << COORD_FRAC_BITS;

   typedef enum logic [2:0] {
      N_IDLE, N_SQ, N_ROOT, N_RND, N_DSET, N_DIV, N_STORE
   } nstate_type;

   nstate_type    state_ff;
   logic          done_ff;
   vec_type       vec_ff;
   vec_type       res_ff;
   logic [1:0]    k_ff;
   logic [31:0]   s_ff;
   logic [31:0]   r_ff;
   logic [31:0]   bit_ff;
   logic [16:0]   d_ff;
   logic [NW-1:0] num_ff;
   logic [16:0]   rem_ff;
   logic [NW-1:0] q_ff;
   logic [CW-1:0] cnt_ff;

   logic signed [31:0] prod;
   logic [31:0]        s_in;
   logic [31:0]        rb;
   logic signed [16:0] ext;
   logic [16:0]        mag;
   logic [17:0]        trial;
   logic               ge;
   logic [NW-1:0]      sat;

   always_comb begin
      prod  = vec_ff[k_ff] * vec_ff[k_ff];
      s_in  = s_ff + unsigned'(prod);
      rb    = r_ff + bit_ff;
      ext   = {vec_ff[k_ff][COORD_W-1], vec_ff[k_ff]};
      mag   = vec_ff[k_ff][COORD_W-1] ? unsigned'(-ext) : unsigned'(ext);
      trial = {rem_ff, num_ff[NW-1]};
      ge    = trial >= {1'b0, d_ff};
      sat   = (q_ff > ONE) ? ONE : q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            N_IDLE: begin
               if (start) begin
                  vec_ff   <= vec_in;
                  s_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= N_SQ;
               end
            end
            N_SQ: begin
               s_ff <= s_in;
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd2) begin
                  if (s_in == '0) begin
                     // zero vector passes through
                     res_ff   <= vec_ff;
                     done_ff  <= 1'b1;
                     state_ff <= N_IDLE;
                  end else begin
                     r_ff     <= '0;
                     bit_ff   <= 32'd1 << 30;
                     state_ff <= N_ROOT;
                  end
               end
            end
            N_ROOT: begin
               if (s_ff >= rb) begin
                  s_ff <= s_ff - rb;
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff == 32'd1) state_ff <= N_RND;
            end
            N_RND: begin
               d_ff     <= 17'(r_ff + ((s_ff > r_ff) ? 32'd1 : 32'd0));
               k_ff     <= '0;
               state_ff <= N_DSET;
            end
            N_DSET: begin
               num_ff   <= (NW'(mag) << COORD_FRAC_BITS) + NW'(d_ff >> 1);
               rem_ff   <= '0;
               q_ff     <= '0;
               cnt_ff   <= '0;
               state_ff <= N_DIV;
            end
            N_DIV: begin
               rem_ff <= ge ? 17'(trial - {1'b0, d_ff}) : trial[16:0];
               q_ff   <= {q_ff[NW-2:0], ge};
               num_ff <= num_ff << 1;
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(NW - 1)) state_ff <= N_STORE;
            end
            N_STORE: begin
               res_ff[k_ff] <= vec_ff[k_ff][COORD_W-1] ? -sat[COORD_W-1:0]
                                                        : sat[COORD_W-1:0];
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd2) begin
                  done_ff  <= 1'b1;
                  state_ff <= N_IDLE;
               end else begin
                  state_ff <= N_DSET;
               end
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// File: rtl/sts_datapath.sv
// datapath: vertex store, midpoint former, normalizer and result corners
module sts_datapath import sts_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  tri_type       in_tri,
   output dp_status_type sts,
   output tri_type       out_tri
);

   vec_type mem [NUM_SLOTS];
   tri_type in_ff;
   vec_type rdata_ff;
   vec_type tmp_ff;
   vec_type vec_ff;
   tri_type out_ff;
   vec_type norm_res;
   vec_type mid;
   logic    norm_done;
   logic signed [COORD_W:0] sum;

   always_comb begin
      mid = '0;
      sum = '0;
      for (int k = 0; k < 3; k++) begin
         sum    = {tmp_ff[k][COORD_W-1], tmp_ff[k]} + {rdata_ff[k][COORD_W-1], rdata_ff[k]};
         mid[k] = sum[COORD_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.in_ld) in_ff <= in_tri;
      if (cmd.wr_en) mem[cmd.wr_addr] <= cmd.wr_from_in ? in_ff[cmd.in_sel] : norm_res;
      if (cmd.rd_en) rdata_ff <= mem[cmd.rd_addr];
      if (cmd.tmp_ld) tmp_ff <= rdata_ff;
      if (cmd.vec_ld) vec_ff <= cmd.vec_mid ? mid : rdata_ff;
      if (cmd.out_ld) out_ff[cmd.out_sel] <= norm_res;
   end

   sts_norm #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.norm_start),
      .vec_in (vec_ff),
      .done   (norm_done),
      .res    (norm_res)
   );

   assign sts.norm_done = norm_done;
   assign out_tri       = out_ff;

endmodule

// File: rtl/sts_ctrl.sv
// controller: depth first walk of the subdivision tree and color counter
module sts_ctrl import sts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_frame_start,
   output logic               req_ready,
   input  logic [DEPTH_W-1:0] depth,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [COLOR_W-1:0] color,
   output logic               last,
   output dp_cmd_type         cmd,
   input  dp_status_type      sts
);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_VISIT, S_LEAFW, S_RD_A, S_RD_B, S_MID, S_NSTART, S_NWAIT, S_ADV
   } state_type;

   state_type          state_ff;
   logic [LVL_W-1:0]   lvl_ff;
   logic [1:0]         pos_ff [MAX_DEPTH+1];
   slot3_type          crn_ff [MAX_DEPTH+1];
   logic [1:0]         e_ff;
   logic [COLOR_W-1:0] cnt_ff;
   logic               valid_ff;
   logic [COLOR_W-1:0] color_ff;
   logic               last_ff;

   logic [LVL_W-1:0]   dcap;
   logic               leaf;
   slot3_type          cur;
   logic [1:0]         e_nx;
   slot_type           u_slot;
   slot_type           v_slot;
   slot_type           dst;
   logic               anc_last;
   logic [LVL_W-1:0]   up;

   always_comb begin
      dcap     = (int'(depth) > MAX_DEPTH) ? LVL_W'(MAX_DEPTH) : LVL_W'(depth);
      leaf     = lvl_ff == dcap;
      cur      = crn_ff[lvl_ff];
      e_nx     = (e_ff == 2'd2) ? 2'd0 : e_ff + 2'd1;
      u_slot   = cur[e_ff];
      v_slot   = leaf ? cur[e_ff] : cur[e_nx];
      dst      = leaf ? u_slot : mid_base(lvl_ff) + SLOT_W'(e_ff);
      up       = lvl_ff - LVL_W'(1);
      anc_last = 1'b1;
      for (int j = 0; j < MAX_DEPTH; j++) begin
         if (j < int'(lvl_ff) && pos_ff[j] != 2'd3) anc_last = 1'b0;
      end

      cmd = '0;
      case (state_ff)
         S_IDLE: cmd.in_ld = req_valid;
         S_LOAD: begin
            cmd.wr_en      = 1'b1;
            cmd.wr_from_in = 1'b1;
            cmd.in_sel     = e_ff;
            cmd.wr_addr    = SLOT_W'(e_ff);
         end
         S_RD_A: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = u_slot;
         end
         S_RD_B: begin
            cmd.tmp_ld  = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = v_slot;
         end
         S_MID: begin
            cmd.vec_ld  = 1'b1;
            cmd.vec_mid = !leaf;
         end
         S_NSTART: cmd.norm_start = 1'b1;
         S_NWAIT: begin
            if (sts.norm_done) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = dst;
               cmd.out_ld  = leaf;
               cmd.out_sel = e_ff;
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lvl_ff   <= '0;
         e_ff     <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
         for (int j = 0; j <= MAX_DEPTH; j++) pos_ff[j] <= '0;
      end else begin
         if (valid_ff && rsp_ready) valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_frame_start) cnt_ff <= '0;
                  e_ff      <= '0;
                  lvl_ff    <= '0;
                  crn_ff[0] <= {SLOT_W'(2), SLOT_W'(1), SLOT_W'(0)};
                  state_ff  <= S_LOAD;
               end
            end
            S_LOAD: begin
               e_ff <= e_nx;
               if (e_ff == 2'd2) state_ff <= S_VISIT;
            end
            S_VISIT: begin
               cnt_ff   <= (int'(cnt_ff) + 1 >= COLOR_MOD) ? '0 : cnt_ff + COLOR_W'(1);
               e_ff     <= '0;
               state_ff <= leaf ? S_LEAFW : S_RD_A;
            end
            // result corners are overwritten only once the previous word left
            S_LEAFW: if (!valid_ff || rsp_ready) state_ff <= S_RD_A;
            S_RD_A:   state_ff <= S_RD_B;
            S_RD_B:   state_ff <= S_MID;
            S_MID:    state_ff <= S_NSTART;
            S_NSTART: state_ff <= S_NWAIT;
            S_NWAIT: begin
               if (sts.norm_done) begin
                  e_ff <= e_nx;
                  if (e_ff != 2'd2) begin
                     state_ff <= S_RD_A;
                  end else if (leaf) begin
                     valid_ff <= 1'b1;
                     color_ff <= cnt_ff;
                     last_ff  <= anc_last;
                     state_ff <= S_ADV;
                  end else begin
                     pos_ff[lvl_ff]                <= '0;
                     crn_ff[lvl_ff + LVL_W'(1)]    <= child_corners(cur, lvl_ff, 2'd0);
                     lvl_ff                        <= lvl_ff + LVL_W'(1);
                     state_ff                      <= S_VISIT;
                  end
               end
            end
            S_ADV: begin
               if (lvl_ff == '0) begin
                  state_ff <= S_IDLE;
               end else if (pos_ff[up] != 2'd3) begin
                  pos_ff[up]     <= pos_ff[up] + 2'd1;
                  crn_ff[lvl_ff] <= child_corners(crn_ff[up], up, pos_ff[up] + 2'd1);
                  state_ff       <= S_VISIT;
               end else begin
                  lvl_ff <= up;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = valid_ff;
   assign color     = color_ff;
   assign last      = last_ff;

endmodule

// File: rtl/sphere_triangle_subdivider.sv
// top level of the sphere triangle subdivider
//
//   port group   dir   word
//   req_*        in    one triangle, tuser = frame start
//   rsp_*        out   one leaf triangle, tlast = final leaf of the input
//   csr_*        in    subdivision depth, write only
//
// one triangle at depth n takes 4^n leaves and (4^n-1) + 4^n*3 normalizations on
// the single shared normalizer.
// reset is synchronous; no clearing pass is needed.
// a stalled result word holds the walk only when the next leaf is ready to load.
`include "sphere_triangle_subdivider_assert.svh"
module sphere_triangle_subdivider import sts_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   input  logic [143:0]       req_tdata,
   // frame_start
   input  logic               req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z, out_c_x, out_c_y,
   // out_c_z, color_step, zero pad
   output logic [151:0]       rsp_tdata,
   output logic               rsp_tlast,
   input  logic               csr_we,
   input  logic [DEPTH_W-1:0] csr_wdata
);

   logic [DEPTH_W-1:0] depth_ff;
   dp_cmd_type         cmd;
   dp_status_type      sts;
   tri_type            out_tri;
   logic [COLOR_W-1:0] color;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
      end else if (csr_we) begin
         depth_ff <= csr_wdata;
      end
   end

   sts_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_frame_start (req_tuser),
      .req_ready       (req_tready),
      .depth           (depth_ff),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .color           (color),
      .last            (rsp_tlast),
      .cmd             (cmd),
      .sts             (sts)
   );

   sts_datapath #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .in_tri  (tri_type'(req_tdata)),
      .sts     (sts),
      .out_tri (out_tri)
   );

   assign rsp_tdata = {1'b0, color, out_tri};

   `STS_ASSERT_IMPLY(a_color_range, clock, reset, rsp_tvalid, rsp_tdata[150:144] < 7'd100)
   `STS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `STS_ASSERT_NEXT(a_busy_until_last, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, !req_tready)

endmodule

// File: tb/tb_sphere_triangle_subdivider.sv
// testbench for the sphere triangle subdivider: predicts leaf triangles and checks the stream
`timescale 1ns / 1ps
module tb_sphere_triangle_subdivider;
   import sts_pkg::*;

   typedef struct {
      logic          frame;
      logic [143:0]  corners;
   } tri_word_type;

   typedef struct {
      logic [151:0]  data;
      logic          last;
   } leaf_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [143:0]       req_tdata = '0;
   logic               req_tuser = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [151:0]       rsp_tdata;
   logic               rsp_tlast;
   logic               csr_we = 1'b0;
   logic [DEPTH_W-1:0] csr_wdata = '0;

   tri_word_type  pending_tris[$];
   leaf_word_type expected_leaves[$];
   int            error_count = 0;
   int            levels_now = 3;
   int            color_now = 0;
   bit            sender_hold = 1'b0;
   int            send_gap = 0;
   int            recv_gap = 0;

   sphere_triangle_subdivider DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint unsigned root_rounded(longint unsigned s);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (s > r) r++;
      return r;
   endfunction

   task automatic to_unit(inout longint v[3]);
      longint unsigned s = 0;
      longint unsigned d;
      longint unsigned mag;
      longint unsigned q;
      longint one = 64'sd1 << COORD_FRAC_DEF;
      for (int k = 0; k < 3; k++) s += v[k] * v[k];
      if (s == 0) return;
      d = root_rounded(s);
      for (int k = 0; k < 3; k++) begin
         mag = (v[k] < 0) ? -v[k] : v[k];
         q = ((mag << COORD_FRAC_DEF) + d / 2) / d;
         if (q > one) q = one;
         v[k] = (v[k] < 0) ? -longint'(q) : longint'(q);
      end
   endtask

   task automatic walk_node(inout longint a[3], inout longint b[3], inout longint c[3],
                            input int depth);
      longint ab[3];
      longint bc[3];
      longint ca[3];
      leaf_word_type w;
      color_now = (color_now + 1 >= COLOR_MOD) ? 0 : color_now + 1;
      if (depth == 0) begin
         to_unit(a);
         to_unit(b);
         to_unit(c);
         w.data = '0;
         for (int k = 0; k < 3; k++) begin
            w.data[16*k +: 16] = a[k][15:0];
            w.data[48+16*k +: 16] = b[k][15:0];
            w.data[96+16*k +: 16] = c[k][15:0];
         end
         w.data[144 +: 7] = color_now[6:0];
         w.last = 1'b0;
         expected_leaves.push_back(w);
         return;
      end
      for (int k = 0; k < 3; k++) begin
         ab[k] = (a[k] + b[k]) >>> 1;
         bc[k] = (b[k] + c[k]) >>> 1;
         ca[k] = (c[k] + a[k]) >>> 1;
      end
      to_unit(ab);
      to_unit(bc);
      to_unit(ca);
      walk_node(a, ab, ca, depth - 1);
      walk_node(b, ab, bc, depth - 1);
      walk_node(ca, c, bc, depth - 1);
      walk_node(ab, ca, bc, depth - 1);
   endtask

   task automatic predict_leaves(tri_word_type t);
      longint a[3];
      longint b[3];
      longint c[3];
      if (t.frame) color_now = 0;
      for (int k = 0; k < 3; k++) begin
         a[k] = longint'($signed(t.corners[16*k +: 16]));
         b[k] = longint'($signed(t.corners[48+16*k +: 16]));
         c[k] = longint'($signed(t.corners[96+16*k +: 16]));
      end
      walk_node(a, b, c, (levels_now > MAX_DEPTH) ? MAX_DEPTH : levels_now);
      expected_leaves[$].last = 1'b1;
   endtask

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 4);
   endfunction

   // sender: one word per handshake, gaps between words
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_leaves(pending_tris.pop_front());
            send_gap = pick_gap();
         end
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_tris.size() > 0 && !sender_hold) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_tris[0].corners;
               req_tuser <= pending_tris[0].frame;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each leaf word against the oldest expectation
   always @(posedge clock) begin
      leaf_word_type w;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_leaves.size() == 0) begin
               report_mismatch("leaf word with nothing expected");
            end else begin
               w = expected_leaves.pop_front();
               for (int f = 0; f < 9; f++)
                  if (rsp_tdata[16*f +: 16] !== w.data[16*f +: 16])
                     report_mismatch($sformatf("corner field %0d got %h want %h", f,
                                     rsp_tdata[16*f +: 16], w.data[16*f +: 16]));
               if (rsp_tdata[144 +: 7] !== w.data[144 +: 7])
                  report_mismatch($sformatf("color step got %0d want %0d",
                                  rsp_tdata[144 +: 7], w.data[144 +: 7]));
               if (rsp_tlast !== w.last)
                  report_mismatch($sformatf("tlast got %b want %b", rsp_tlast, w.last));
            end
            recv_gap = pick_gap();
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'h8000;
         3: return 16'h0000;
         4: return 16'($urandom);
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   task automatic queue_tri(logic frame, logic [15:0] c[9]);
      tri_word_type t;
      t.frame = frame;
      for (int k = 0; k < 9; k++) t.corners[16*k +: 16] = c[k];
      pending_tris.push_back(t);
   endtask

   task automatic queue_random(int n);
      logic [15:0] c[9];
      repeat (n) begin
         for (int k = 0; k < 9; k++) c[k] = rand_coord();
         queue_tri(($urandom_range(0, 7) == 0), c);
      end
   endtask

   task automatic drain_then_config(logic [DEPTH_W-1:0] depth);
      wait (pending_tris.size() == 0 && !req_tvalid);
      wait (expected_leaves.size() == 0);
      repeat (200) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= depth;
      @(posedge clock);
      csr_we <= 1'b0;
      levels_now = depth;
   endtask

   initial begin
      logic [15:0] c[9];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed: octant face, zero corners, extremes, all-ones pattern
      c = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
      queue_tri(1'b1, c);
      c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      queue_tri(1'b0, c);
      c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0};
      queue_tri(1'b0, c);
      c = '{16'hffff, 16'hffff, 16'hffff, 16'hc000, 16'h4000, 16'h0000,
            16'h0001, 16'hffff, 16'h0001};
      queue_tri(1'b1, c);
      drain_then_config(2'd0);
      c = '{16384, 0, 0, 16'hc000, 0, 0, 0, 0, 16'hc000};
      queue_tri(1'b0, c);
      queue_random(60);
      drain_then_config(2'd1);
      queue_random(40);
      // sender waits until all leaves are out
      wait (pending_tris.size() == 0 && !req_tvalid);
      sender_hold = 1'b1;
      wait (expected_leaves.size() == 0);
      sender_hold = 1'b0;
      queue_random(20);
      drain_then_config(2'd2);
      queue_random(16);
      drain_then_config(2'd3);
      queue_random(8);
      wait (pending_tris.size() == 0 && !req_tvalid);
      wait (expected_leaves.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sts_pkg.sv
rtl/sts_norm.sv
rtl/sts_datapath.sv
rtl/sts_ctrl.sv
rtl/sphere_triangle_subdivider.sv
tb/tb_sphere_triangle_subdivider.sv
